[rtl/dnsd_pkg.sv]
// Package for the DNS name decompressor: shared types, codes and widths.
// Used by every module under rtl except dnsd_ram; depends on nothing else.
package dnsd_pkg;

  // Transfer kinds on the command port
  localparam logic [1:0] KIND_CLEAR  = 2'd0;
  localparam logic [1:0] KIND_APPEND = 2'd1;
  localparam logic [1:0] KIND_DECODE = 2'd2;

  // Result error codes
  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_OVERRUN  = 2'd1;
  localparam logic [1:0] ERR_HOPS     = 2'd2;
  localparam logic [1:0] ERR_TOO_LONG = 2'd3;

  // Walk position: covers a 14-bit pointer target or an 11-bit store index plus a name
  localparam int POS_W = 17;

  // Name buffer: a name of at most 255 wire bytes spells at most 253 characters
  localparam int NAME_AW    = 8;
  localparam int NAME_DEPTH = 256;

  localparam logic [1:0] PTR_MARK = 2'b11;
  localparam logic [7:0] DOT_CHAR = 8'h2e;

  typedef enum logic [2:0] {
    W_IDLE,
    W_RDLEN,
    W_LEN,
    W_PTR2,
    W_LABEL,
    W_FINISH
  } walk_state_t;

  typedef enum logic {
    E_IDLE,
    E_RUN
  } emit_state_t;

  // Outcome of one walk, handed from the walker to the emitter
  typedef struct packed {
    logic [1:0]         err;
    logic [NAME_AW-1:0] nlen;
    logic [8:0]         cons;
  } walk_res_t;

endpackage

[rtl/dnsd_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Stand-alone; used for the packet store and the name buffer.
module dnsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and register the read word
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[rtl/dnsd_walk.sv]
// Label walker: steps through the packet store one byte per cycle, follows
// compression pointers and copies the dotted name into the name buffer.
// Depends on dnsd_pkg; drives the read port of the packet store RAM.
module dnsd_walk #(
  parameter int PACKET_BYTES   = 2048,
  parameter int MAX_NAME_CHARS = 255,
  parameter int MAX_HOPS       = 16,
  localparam int AW    = $clog2(PACKET_BYTES),
  localparam int LEN_W = $clog2(PACKET_BYTES + 1),
  localparam int HOP_W = $clog2(MAX_HOPS + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  logic [10:0]                   start_offset,
  input  logic [LEN_W-1:0]              loaded_len,
  output logic [AW-1:0]                 pkt_raddr,
  input  logic [7:0]                    pkt_rdata,
  output logic                          name_we,
  output logic [dnsd_pkg::NAME_AW-1:0]  name_waddr,
  output logic [7:0]                    name_wdata,
  output logic                          busy,
  output logic                          done,
  output dnsd_pkg::walk_res_t           res
);
  import dnsd_pkg::*;

  walk_state_t state, state_next;

  logic [POS_W-1:0]   pos, pos_next;
  logic [POS_W-1:0]   cur, cur_next;
  logic [5:0]         ptr_hi, ptr_hi_next;
  logic [7:0]         lab_len, lab_len_next;
  logic [7:0]         rem, rem_next;
  logic               pend, pend_next;
  logic [HOP_W-1:0]   hops, hops_next;
  logic [8:0]         wire_len, wire_len_next;
  logic [8:0]         cons, cons_next;
  logic               jumped, jumped_next;
  logic [NAME_AW-1:0] nlen, nlen_next;
  logic [1:0]         err, err_next;

  // Shared address compare against the loaded length
  logic [POS_W-1:0] cmp_addr;
  logic             addr_ok;

  logic       is_ptr, is_root, too_long, hop_over, label_end;
  logic [9:0] wire_need;

  always_comb begin
    unique case (state)
      W_LEN:   cmp_addr = pos + POS_W'(1);
      W_LABEL: cmp_addr = cur;
      default: cmp_addr = pos;
    endcase
  end

  assign addr_ok   = cmp_addr < POS_W'(loaded_len);
  assign pkt_raddr = cmp_addr[AW-1:0];

  // Decode the byte just read
  assign is_ptr    = pkt_rdata[7:6] == PTR_MARK;
  assign is_root   = pkt_rdata == 8'd0;
  assign wire_need = 10'(wire_len) + 10'(pkt_rdata) + 10'd2;
  assign too_long  = wire_need > 10'(MAX_NAME_CHARS);
  assign hop_over  = hops == HOP_W'(MAX_HOPS);
  assign label_end = (rem == 8'd0) && !pend;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      W_IDLE:   if (go) state_next = W_RDLEN;
      W_RDLEN:  state_next = addr_ok ? W_LEN : W_FINISH;
      W_LEN: begin
        priority if (is_ptr) state_next = addr_ok ? W_PTR2 : W_FINISH;
        else if (is_root)    state_next = W_FINISH;
        else if (too_long)   state_next = W_FINISH;
        else                 state_next = W_LABEL;
      end
      W_PTR2:   state_next = hop_over ? W_FINISH : W_RDLEN;
      W_LABEL: begin
        priority if (rem != 8'd0 && !addr_ok) state_next = W_FINISH;
        else if (label_end)                   state_next = W_RDLEN;
        else                                  state_next = W_LABEL;
      end
      W_FINISH: state_next = W_IDLE;
      default:  state_next = W_IDLE;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    pos_next      = pos;
    cur_next      = cur;
    ptr_hi_next   = ptr_hi;
    lab_len_next  = lab_len;
    rem_next      = rem;
    pend_next     = pend;
    hops_next     = hops;
    wire_len_next = wire_len;
    cons_next     = cons;
    jumped_next   = jumped;
    nlen_next     = nlen;
    err_next      = err;
    name_we       = 1'b0;
    name_waddr    = nlen;
    name_wdata    = pkt_rdata;
    unique case (state)
      W_IDLE: begin
        if (go) begin
          pos_next      = POS_W'(start_offset);
          hops_next     = '0;
          wire_len_next = '0;
          cons_next     = '0;
          jumped_next   = 1'b0;
          nlen_next     = '0;
          err_next      = ERR_OK;
        end
      end
      W_RDLEN: begin
        if (!addr_ok) err_next = ERR_OVERRUN;
      end
      W_LEN: begin
        priority if (is_ptr) begin
          ptr_hi_next = pkt_rdata[5:0];
          if (!addr_ok) err_next = ERR_OVERRUN;
        end else if (is_root) begin
          if (!jumped) cons_next = cons + 9'd1;
        end else if (too_long) begin
          err_next = ERR_TOO_LONG;
        end else begin
          // Separate labels with a dot, then copy the label body
          if (nlen != '0) begin
            name_we    = 1'b1;
            name_wdata = DOT_CHAR;
            nlen_next  = nlen + NAME_AW'(1);
          end
          lab_len_next = pkt_rdata;
          rem_next     = pkt_rdata;
          cur_next     = pos + POS_W'(1);
          pend_next    = 1'b0;
        end
      end
      W_PTR2: begin
        if (!jumped) begin
          cons_next   = cons + 9'd2;
          jumped_next = 1'b1;
        end
        if (hop_over) begin
          err_next = ERR_HOPS;
        end else begin
          hops_next = hops + HOP_W'(1);
          pos_next  = POS_W'({ptr_hi, pkt_rdata});
        end
      end
      W_LABEL: begin
        // Store the byte read last cycle, issue the next read
        if (pend) begin
          name_we   = 1'b1;
          nlen_next = nlen + NAME_AW'(1);
        end
        if (rem != 8'd0) begin
          if (addr_ok) begin
            cur_next  = cur + POS_W'(1);
            rem_next  = rem - 8'd1;
            pend_next = 1'b1;
          end else begin
            err_next = ERR_OVERRUN;
          end
        end else begin
          pend_next = 1'b0;
        end
        if (label_end) begin
          wire_len_next = wire_len + 9'(lab_len) + 9'd1;
          if (!jumped) cons_next = cons + 9'(lab_len) + 9'd1;
          pos_next = cur;
        end
      end
      W_FINISH: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= W_IDLE;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      pend  <= pend_next;
    end
    pos      <= pos_next;
    cur      <= cur_next;
    ptr_hi   <= ptr_hi_next;
    lab_len  <= lab_len_next;
    rem      <= rem_next;
    hops     <= hops_next;
    wire_len <= wire_len_next;
    cons     <= cons_next;
    jumped   <= jumped_next;
    nlen     <= nlen_next;
    err      <= err_next;
  end

  assign busy     = state != W_IDLE;
  assign done     = state == W_FINISH;
  assign res.err  = err;
  assign res.nlen = nlen;
  assign res.cons = cons;

endmodule

[rtl/dnsd_emit.sv]
// Result emitter: reads the finished name from the name buffer and strobes it
// out up to eight characters per result. Depends on dnsd_pkg.
module dnsd_emit (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  dnsd_pkg::walk_res_t           res,
  output logic [dnsd_pkg::NAME_AW-1:0]  name_raddr,
  input  logic [7:0]                    name_rdata,
  output logic                          busy,
  output logic                          valid,
  output logic [63:0]                   name_chars,
  output logic [3:0]                    char_count,
  output logic                          last,
  output logic [8:0]                    consumed,
  output logic [1:0]                    error_code
);
  import dnsd_pkg::*;

  emit_state_t state, state_next;

  logic [NAME_AW-1:0] idx, idx_next;
  logic [NAME_AW-1:0] nlen, nlen_next;
  logic [8:0]         cons, cons_next;
  logic [3:0]         slot, slot_next;
  logic               pend, pend_next;
  logic [63:0]        chars, chars_next;

  logic        valid_next;
  logic [63:0] name_chars_next;
  logic [3:0]  char_count_next;
  logic        last_next;
  logic [8:0]  consumed_next;
  logic [1:0]  error_code_next;

  logic [3:0] issued;
  logic       issue, flush, at_end;

  assign issued     = slot + 4'(pend);
  assign at_end     = idx == nlen;
  assign issue      = (issued < 4'd8) && !at_end;
  assign flush      = !issue && !pend;
  assign name_raddr = idx;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      E_IDLE: if (go && res.err == ERR_OK) state_next = E_RUN;
      E_RUN:  if (flush && at_end) state_next = E_IDLE;
      default: state_next = E_IDLE;
    endcase
  end

  // Datapath and result register
  always_comb begin
    idx_next        = idx;
    nlen_next       = nlen;
    cons_next       = cons;
    slot_next       = slot;
    pend_next       = pend;
    chars_next      = chars;
    valid_next      = 1'b0;
    name_chars_next = name_chars;
    char_count_next = char_count;
    last_next       = last;
    consumed_next   = consumed;
    error_code_next = error_code;
    unique case (state)
      E_IDLE: begin
        if (go) begin
          if (res.err != ERR_OK) begin
            // Error: one empty final result
            valid_next      = 1'b1;
            name_chars_next = '0;
            char_count_next = '0;
            last_next       = 1'b1;
            consumed_next   = '0;
            error_code_next = res.err;
          end else begin
            idx_next   = '0;
            nlen_next  = res.nlen;
            cons_next  = res.cons;
            slot_next  = '0;
            pend_next  = 1'b0;
            chars_next = '0;
          end
        end
      end
      E_RUN: begin
        // Place the character read last cycle
        if (pend) begin
          chars_next[{slot[2:0], 3'b000} +: 8] = name_rdata;
          slot_next = slot + 4'd1;
        end
        if (issue) idx_next = idx + NAME_AW'(1);
        pend_next = issue;
        if (flush) begin
          valid_next      = 1'b1;
          name_chars_next = chars;
          char_count_next = slot;
          last_next       = at_end;
          consumed_next   = at_end ? cons : 9'd0;
          error_code_next = ERR_OK;
          chars_next      = '0;
          slot_next       = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= E_IDLE;
      valid <= 1'b0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      valid <= valid_next;
      pend  <= pend_next;
    end
    idx        <= idx_next;
    nlen       <= nlen_next;
    cons       <= cons_next;
    slot       <= slot_next;
    chars      <= chars_next;
    name_chars <= name_chars_next;
    char_count <= char_count_next;
    last       <= last_next;
    consumed   <= consumed_next;
    error_code <= error_code_next;
  end

  assign busy = state != E_IDLE;

endmodule

[rtl/dns_name_decompressor.sv]
// DNS name decompressor, top level.
// Command port: a transfer is taken at a clock edge with start high and busy
// low. kind selects clear (empty the store), append (data_byte goes at the
// end of the store, dropped when full) or decode (walk the name at
// start_offset). Clear and append never raise busy; the unused kind is
// ignored. A decode raises busy from the next cycle. The walker reads one
// packet byte per cycle through the store's read port, taking the length
// bytes, label characters, pointer bytes and closing zero byte in turn. The
// emitter then reads the name buffer one character a cycle while it fills a
// result. Results appear for exactly one cycle each, marked by valid, the
// final one with last set and consumed filled in; an error yields a single
// empty final result carrying error_code. The receiver cannot hold results
// off. busy falls in the cycle of the final result.
// Reset empties the store (loaded length zero) and idles both sequencers; the
// store contents are not cleared and need no clearing pass.
// Depends on dnsd_pkg, dnsd_ram, dnsd_walk and dnsd_emit.
module dns_name_decompressor #(
  parameter int PACKET_BYTES   = 2048,
  parameter int MAX_NAME_CHARS = 255,
  parameter int MAX_HOPS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [10:0] start_offset,
  output logic        valid,
  output logic [63:0] name_chars,
  output logic [3:0]  char_count,
  output logic        last,
  output logic [8:0]  consumed,
  output logic [1:0]  error_code
);
  import dnsd_pkg::*;

  localparam int AW    = $clog2(PACKET_BYTES);
  localparam int LEN_W = $clog2(PACKET_BYTES + 1);

  logic [LEN_W-1:0]   loaded_len;
  logic               accept, append_we, walk_go;
  logic [AW-1:0]      pkt_raddr;
  logic [7:0]         pkt_rdata;
  logic               name_we;
  logic [NAME_AW-1:0] name_waddr, name_raddr;
  logic [7:0]         name_wdata, name_rdata;
  logic               walk_busy, walk_done, emit_busy;
  walk_res_t          walk_res;

  assign busy      = walk_busy | emit_busy;
  assign accept    = start & ~busy;
  assign append_we = accept && (kind == KIND_APPEND) && (loaded_len < LEN_W'(PACKET_BYTES));
  assign walk_go   = accept && (kind == KIND_DECODE);

  // Track the fill level of the packet store
  always_ff @(posedge clk) begin
    if (rst) begin
      loaded_len <= '0;
    end else if (accept && kind == KIND_CLEAR) begin
      loaded_len <= '0;
    end else if (append_we) begin
      loaded_len <= loaded_len + LEN_W'(1);
    end
  end

  dnsd_ram #(
    .WIDTH (8),
    .DEPTH (PACKET_BYTES)
  ) u_pkt_ram (
    .clk   (clk),
    .we    (append_we),
    .waddr (loaded_len[AW-1:0]),
    .wdata (data_byte),
    .raddr (pkt_raddr),
    .rdata (pkt_rdata)
  );

  dnsd_ram #(
    .WIDTH (8),
    .DEPTH (NAME_DEPTH)
  ) u_name_ram (
    .clk   (clk),
    .we    (name_we),
    .waddr (name_waddr),
    .wdata (name_wdata),
    .raddr (name_raddr),
    .rdata (name_rdata)
  );

  dnsd_walk #(
    .PACKET_BYTES   (PACKET_BYTES),
    .MAX_NAME_CHARS (MAX_NAME_CHARS),
    .MAX_HOPS       (MAX_HOPS)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .go           (walk_go),
    .start_offset (start_offset),
    .loaded_len   (loaded_len),
    .pkt_raddr    (pkt_raddr),
    .pkt_rdata    (pkt_rdata),
    .name_we      (name_we),
    .name_waddr   (name_waddr),
    .name_wdata   (name_wdata),
    .busy         (walk_busy),
    .done         (walk_done),
    .res          (walk_res)
  );

  dnsd_emit u_emit (
    .clk        (clk),
    .rst        (rst),
    .go         (walk_done),
    .res        (walk_res),
    .name_raddr (name_raddr),
    .name_rdata (name_rdata),
    .busy       (emit_busy),
    .valid      (valid),
    .name_chars (name_chars),
    .char_count (char_count),
    .last       (last),
    .consumed   (consumed),
    .error_code (error_code)
  );

`ifndef ASSERT_OFF
  // An error result carries no characters and ends the decode
  a_err_result: assert property (@(posedge clk) disable iff (rst)
    valid && error_code != ERR_OK |-> last && char_count == 4'd0 && consumed == 9'd0)
    else $error("error result not empty and final");

  // Every result but the final one is full
  a_full_mid: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> char_count == 4'd8 && consumed == 9'd0)
    else $error("non-final result not full");

  // A good final result always reports at least one consumed byte
  a_consumed: assert property (@(posedge clk) disable iff (rst)
    valid && last && error_code == ERR_OK |-> consumed != 9'd0)
    else $error("final result with zero consumed");

  // No decode may begin while the emitter still owes results
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    emit_busy |-> !walk_busy)
    else $error("walker and emitter active together");
`endif

endmodule

[verif/dnsd_checker.sv]
// Scoreboard for the DNS name decompressor: mirrors the packet store, walks each
// decoded name itself and compares every result beat. Depends on dnsd_pkg only.
`timescale 1ns / 100ps

module dnsd_checker #(
  parameter int PACKET_BYTES   = 2048,
  parameter int MAX_NAME_CHARS = 255,
  parameter int MAX_HOPS       = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [1:0]  kind,
  input  logic [7:0]  data_byte,
  input  logic [10:0] start_offset,
  input  logic        valid,
  input  logic [63:0] name_chars,
  input  logic [3:0]  char_count,
  input  logic        last,
  input  logic [8:0]  consumed,
  input  logic [1:0]  error_code,
  output int          fail_count,
  output int          pending_results
);
  import dnsd_pkg::*;

  // One result beat as the block should present it
  typedef struct {
    logic [63:0] chars;
    logic [3:0]  count;
    logic        fin;
    logic [8:0]  cons;
    logic [1:0]  err;
  } name_beat_t;

  name_beat_t  name_beats_q[$];
  logic [7:0]  msg_mem [PACKET_BYTES];
  int unsigned msg_len;

  initial fail_count = 0;

  // Read one stored byte; false when the position lies beyond the loaded message
  function automatic logic fetch_msg_byte(input int unsigned p, output logic [7:0] b);
    b = 8'h00;
    if (p >= msg_len || p >= PACKET_BYTES) return 1'b0;
    b = msg_mem[p];
    return 1'b1;
  endfunction

  // Walk the name at ofs and queue the beats it must produce
  function automatic void spell_name(input int unsigned ofs);
    logic [7:0]  spelled [256];
    int unsigned nlen, p, hops, wire_len, cons, n, k, nbeats, r, j;
    logic        jumped, done;
    logic [1:0]  err;
    logic [7:0]  b, b2, c;
    name_beat_t  beat;
    nlen = 0; p = ofs; hops = 0; wire_len = 0; cons = 0;
    jumped = 1'b0; done = 1'b0; err = ERR_OK;
    while (!done) begin
      if (!fetch_msg_byte(p, b)) begin
        err = ERR_OVERRUN;
        done = 1'b1;
      end else if (b[7:6] == PTR_MARK) begin
        // follow a compression pointer; only the first one counts towards consumed
        if (!fetch_msg_byte(p + 1, b2)) begin
          err = ERR_OVERRUN;
          done = 1'b1;
        end else begin
          if (!jumped) begin
            cons += 2;
            jumped = 1'b1;
          end
          hops++;
          if (hops > MAX_HOPS) begin
            err = ERR_HOPS;
            done = 1'b1;
          end else begin
            p = {b[5:0], b2};
          end
        end
      end else if (b == 8'h00) begin
        if (!jumped) cons += 1;
        done = 1'b1;
      end else begin
        // plain label, reserved types included; the wire limit is checked first
        n = b;
        if (wire_len + n + 2 > MAX_NAME_CHARS) begin
          err = ERR_TOO_LONG;
          done = 1'b1;
        end else begin
          if (nlen > 0 && nlen < 256) begin
            spelled[nlen] = DOT_CHAR;
            nlen++;
          end
          for (k = 0; k < n && err == ERR_OK; k++) begin
            if (!fetch_msg_byte(p + 1 + k, c)) err = ERR_OVERRUN;
            else if (nlen < 256) begin
              spelled[nlen] = c;
              nlen++;
            end
          end
          if (err != ERR_OK) done = 1'b1;
          else begin
            wire_len += n + 1;
            if (!jumped) cons += n + 1;
            p += n + 1;
          end
        end
      end
    end

    // an error gives a single empty final beat
    if (err != ERR_OK) begin
      beat.chars = '0;
      beat.count = '0;
      beat.fin   = 1'b1;
      beat.cons  = '0;
      beat.err   = err;
      name_beats_q.push_back(beat);
      return;
    end

    // split the dotted name into beats of eight characters
    nbeats = (nlen == 0) ? 1 : (nlen + 7) / 8;
    if (nbeats > 32) nbeats = 32;
    for (r = 0; r < nbeats; r++) begin
      beat.chars = '0;
      beat.count = '0;
      for (j = 0; j < 8 && r * 8 + j < nlen; j++) begin
        beat.chars[8*j +: 8] = spelled[r * 8 + j];
        beat.count++;
      end
      beat.fin  = (r + 1 == nbeats);
      beat.cons = beat.fin ? 9'(cons) : 9'd0;
      beat.err  = ERR_OK;
      name_beats_q.push_back(beat);
    end
  endfunction

  // Compare results against the oldest expectation, then mirror each accepted transfer
  always @(posedge clk) begin
    name_beat_t want;
    if (rst) begin
      msg_len = 0;
      name_beats_q.delete();
      pending_results <= 0;
    end else begin
      if (valid) begin
        if (name_beats_q.size() == 0) begin
          $error("unexpected result: name_chars %h char_count %0d last %0b error_code %0d",
                 name_chars, char_count, last, error_code);
          fail_count++;
        end else begin
          want = name_beats_q.pop_front();
          if (name_chars !== want.chars) begin
            $error("name_chars: expected %h, actual %h", want.chars, name_chars);
            fail_count++;
          end
          if (char_count !== want.count) begin
            $error("char_count: expected %0d, actual %0d", want.count, char_count);
            fail_count++;
          end
          if (last !== want.fin) begin
            $error("last: expected %0b, actual %0b", want.fin, last);
            fail_count++;
          end
          if (consumed !== want.cons) begin
            $error("consumed: expected %0d, actual %0d", want.cons, consumed);
            fail_count++;
          end
          if (error_code !== want.err) begin
            $error("error_code: expected %0d, actual %0d", want.err, error_code);
            fail_count++;
          end
        end
      end

      if (start && !busy) begin
        case (kind)
          KIND_CLEAR: msg_len = 0;
          KIND_APPEND: begin
            // drop the byte once the store is full
            if (msg_len < PACKET_BYTES) begin
              msg_mem[msg_len] = data_byte;
              msg_len++;
            end
          end
          KIND_DECODE: spell_name(start_offset);
          default: ;
        endcase
      end
      pending_results <= name_beats_q.size();
    end
  end

endmodule

[verif/dns_name_decompressor_tb.sv]
// Testbench top for dns_name_decompressor: builds DNS messages with labels and
// compression pointers, loads them and requests decodes. Depends on dnsd_pkg,
// the block under rtl and dnsd_checker, which predicts and compares results.
`timescale 1ns / 100ps

module dns_name_decompressor_tb;
  import dnsd_pkg::*;

  localparam int PACKET_BYTES   = 2048;
  localparam int MAX_NAME_CHARS = 255;
  localparam int MAX_HOPS       = 16;
  localparam int RANDOM_ITEMS   = 480;
  localparam logic [1:0] KIND_SPARE = 2'd3;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  kind;
  logic [7:0]  data_byte;
  logic [10:0] start_offset;
  logic        valid;
  logic [63:0] name_chars;
  logic [3:0]  char_count;
  logic        last;
  logic [8:0]  consumed;
  logic [1:0]  error_code;
  int          fail_count;
  int          pending_results;

  logic [7:0]  msg_bytes[$];
  int          name_starts[$];
  logic        pace_on;
  int          sent_items;

  dns_name_decompressor #(
    .PACKET_BYTES  (PACKET_BYTES),
    .MAX_NAME_CHARS(MAX_NAME_CHARS),
    .MAX_HOPS      (MAX_HOPS)
  ) dut (
    .clk, .rst, .start, .busy, .kind, .data_byte, .start_offset,
    .valid, .name_chars, .char_count, .last, .consumed, .error_code
  );

  dnsd_checker #(
    .PACKET_BYTES  (PACKET_BYTES),
    .MAX_NAME_CHARS(MAX_NAME_CHARS),
    .MAX_HOPS      (MAX_HOPS)
  ) chk (
    .clk, .rst, .start, .busy, .kind, .data_byte, .start_offset,
    .valid, .name_chars, .char_count, .last, .consumed, .error_code,
    .fail_count, .pending_results
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Give up on a hung run
  initial begin
    #20_000_000;
    $display("dns_name_decompressor verification failed");
    $finish;
  end

  // Present one command and hold it until the transfer happens
  task automatic put_cmd(input logic [1:0] k, input logic [7:0] b, input logic [10:0] o);
    int gap;
    gap = pace_on ? $urandom_range(0, 5) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start        <= 1'b1;
    kind         <= k;
    data_byte    <= b;
    start_offset <= o;
    do @(posedge clk); while (busy);
    if (k != KIND_SPARE) sent_items++;
  endtask

  // Hold off until every predicted result has arrived
  task automatic settle();
    start <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
  endtask

  // Clear the store and append the composed message byte by byte
  task automatic load_message();
    put_cmd(KIND_CLEAR, 8'($urandom), 11'($urandom));
    foreach (msg_bytes[i]) put_cmd(KIND_APPEND, msg_bytes[i], 11'($urandom));
  endtask

  // Mostly short labels, some up to 63, a few reserved label types
  function automatic logic [7:0] draw_label_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 8'($urandom_range(1, 8));
    if (r < 94) return 8'($urandom_range(9, 63));
    return 8'($urandom_range(64, 191));
  endfunction

  // Compose a message of names that end in a zero byte or point back to earlier
  // names; pointer-only names build hop chains, the odd pointer goes anywhere
  function automatic void compose_message(input int target);
    int          here, style, nlab, len, chain_tail;
    logic        ends_in_ptr;
    logic [13:0] ptgt;
    msg_bytes.delete();
    name_starts.delete();
    chain_tail = -1;
    while (msg_bytes.size() < target) begin
      here = msg_bytes.size();
      style = $urandom_range(0, 9);
      ends_in_ptr = 1'b1;
      ptgt = '0;
      if (style < 2 && name_starts.size() != 0) begin
        if (style == 0 && chain_tail >= 0) ptgt = 14'(chain_tail);
        else ptgt = 14'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
        if (style == 0) chain_tail = here;
      end else begin
        nlab = $urandom_range(0, 4);
        repeat (nlab) begin
          len = draw_label_len();
          msg_bytes.push_back(8'(len));
          repeat (len) msg_bytes.push_back(8'($urandom_range(0, 255)));
        end
        style = $urandom_range(0, 19);
        if (style < 7 && name_starts.size() != 0)
          ptgt = 14'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
        else if (style == 7) ptgt = 14'($urandom_range(0, 16383));
        else begin
          msg_bytes.push_back(8'h00);
          ends_in_ptr = 1'b0;
        end
      end
      if (ends_in_ptr) begin
        msg_bytes.push_back({2'b11, ptgt[13:8]});
        msg_bytes.push_back(ptgt[7:0]);
      end
      name_starts.push_back(here);
    end
    while (msg_bytes.size() > target) void'(msg_bytes.pop_back());
  endfunction

  initial begin
    int         seed_offs[$];
    int         rounds, n_dec, pick;
    logic [10:0] ofs;
    rst          = 1'b1;
    start        = 1'b0;
    kind         = KIND_CLEAR;
    data_byte    = 8'h00;
    start_offset = 11'd0;
    pace_on      = 1'b0;
    sent_items   = 0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Directed: plain name, pointer, root, pointer loop, far pointer target,
    // reserved and long labels running off the end, truncated pointer, far offset
    msg_bytes = '{8'h03, 8'h77, 8'h77, 8'h77, 8'h07, 8'h65, 8'h78, 8'h61, 8'h6d,
                  8'h70, 8'h6c, 8'h65, 8'h00, 8'hc0, 8'h04, 8'h00, 8'hc0, 8'h10,
                  8'hfe, 8'h80, 8'hff};
    seed_offs = '{0, 13, 12, 15, 16, 18, 19, 20, 1, 2047};
    load_message();
    foreach (seed_offs[i]) put_cmd(KIND_DECODE, 8'hff, 11'(seed_offs[i]));
    put_cmd(KIND_SPARE, 8'hff, 11'h7ff);
    put_cmd(KIND_DECODE, 8'h00, 11'd0);
    settle();

    // Fill the store to the brim, push two more bytes that must be dropped
    compose_message(PACKET_BYTES);
    load_message();
    put_cmd(KIND_APPEND, 8'hff, 11'h000);
    put_cmd(KIND_APPEND, 8'h00, 11'h7ff);
    pace_on = 1'b1;
    put_cmd(KIND_DECODE, 8'($urandom), 11'h7ff);
    repeat (40) begin
      if ($urandom_range(0, 1) == 0)
        ofs = 11'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
      else
        ofs = 11'($urandom_range(0, 2047));
      put_cmd(KIND_DECODE, 8'($urandom), ofs);
    end
    settle();

    // An empty store must overrun at once
    put_cmd(KIND_CLEAR, 8'($urandom), 11'($urandom));
    put_cmd(KIND_DECODE, 8'($urandom), 11'd0);

    // Random: small messages, mostly decodes at real name starts
    sent_items = 0;
    rounds = 0;
    while (sent_items < RANDOM_ITEMS) begin
      pace_on = ($urandom_range(0, 2) != 0);
      compose_message($urandom_range(8, 60));
      load_message();
      n_dec = $urandom_range(6, 16);
      repeat (n_dec) begin
        pick = $urandom_range(0, 19);
        if (pick < 16)
          ofs = 11'(name_starts[$urandom_range(0, name_starts.size() - 1)]);
        else if (pick < 19)
          ofs = 11'($urandom_range(0, msg_bytes.size() + 3));
        else
          ofs = 11'($urandom_range(0, 2047));
        if ($urandom_range(0, 15) == 0)
          put_cmd(KIND_SPARE, 8'($urandom), 11'($urandom));
        put_cmd(KIND_DECODE, 8'($urandom), ofs);
      end
      rounds++;
      if (rounds % 4 == 0) settle();
    end

    // Drain, then watch a while for stray results
    settle();
    repeat (400) @(posedge clk);
    if (fail_count == 0)
      $display("dns_name_decompressor verification clean");
    else
      $display("dns_name_decompressor verification failed");
    $finish;
  end

endmodule
